@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge, reset included
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

// checked at rising edges outside reset
`define ASSERT_CLK_RST(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

@@ rtl/core/rlpid_pkg.sv @@
package rlpid_pkg;

  localparam int unsigned ERROR_LIMIT_DEFAULT = 32'd1048576;

  localparam int DATA_W    = 32;  // Q15.16 values
  localparam int TIME_W    = 24;  // Q8.16 step time
  localparam int RATE_W    = 31;  // max_rate magnitude
  localparam int STATE_W   = 48;  // integral and drive accumulator
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KP       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_OUT = 4'd7;

  localparam logic signed [DATA_W-1:0] KP_RST      = 32'sd65536;
  localparam logic signed [DATA_W-1:0] KI_RST      = 32'sd65536;
  localparam logic signed [DATA_W-1:0] KD_RST      = 32'sd0;
  localparam logic signed [DATA_W-1:0] TARGET_RST  = 32'sd0;
  localparam logic [RATE_W-1:0]        MAX_RATE_RST = 31'd327680;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 32'sd2293760;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST = -32'sd2293760;

  localparam logic signed [STATE_W-1:0] SAT_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] SAT_MIN = {1'b1, {(STATE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
    logic signed [DATA_W-1:0] target;
    logic [RATE_W-1:0]        max_rate;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] out_min;
    logic                     acc_load;
    logic signed [DATA_W-1:0] init_val;
  } rlpid_cfg_t;

endpackage

@@ rtl/core/rate_limited_pid_heading_regulator_unit.sv @@
// datapath: an input beat runs through two bit-serial multiply passes, first over the
//   step_time bits, then over the ki bits against the updated integral, followed by
//   add, limit, accumulate and clamp steps before the result is valid
// flow: one item at a time; a new item is taken only once the last result is in
//   the output register, which holds that result while the next item is taken
// reset: synchronous active low; gains and limits to defaults, state to zero
module rate_limited_pid_heading_regulator_unit #(
  parameter int unsigned ERROR_LIMIT = rlpid_pkg::ERROR_LIMIT_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [rlpid_pkg::DATA_W-1:0]    in_measured,
  input  logic [rlpid_pkg::TIME_W-1:0]           in_step_time,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [rlpid_pkg::DATA_W-1:0]    out_drive,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rlpid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rlpid_pkg::DATA_W-1:0]           cfg_data
);

  import rlpid_pkg::*;

  // error width follows the clamp limit
  localparam int EW   = $clog2(64'(ERROR_LIMIT) + 64'd1) + 1;
  localparam int EPW  = EW + TIME_W;           // error * dt
  localparam int BPW  = DATA_W + TIME_W;       // max_rate * dt
  localparam int PPW  = DATA_W + EW;           // kp * error
  localparam int DPW  = DATA_W + EW + 1;       // kd * diff
  localparam int IPW  = STATE_W + DATA_W;      // ki * integral
  localparam int IW   = IPW - FRAC_W + 2;      // increment sum
  localparam int LW   = BPW - FRAC_W + 1;      // limited increment
  localparam int SW1  = STATE_W + 1;
  localparam int DW1  = DATA_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GO1  = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_ISUM = 4'd3;
  localparam logic [3:0] S_GO2  = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_ADD1 = 4'd6;
  localparam logic [3:0] S_ADD2 = 4'd7;
  localparam logic [3:0] S_LIM  = 4'd8;
  localparam logic [3:0] S_ACC  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  rlpid_cfg_t cfg;

  logic [3:0] state_r, state_nxt;
  logic       in_fire, out_free;
  logic       out_valid_r;
  logic signed [DATA_W-1:0] out_drive_r, drive_nxt;

  logic [TIME_W-1:0]        dt_r;
  logic signed [EW-1:0]     err_r, err_nxt, last_err_r;
  logic signed [EW:0]       diff_r, diff_nxt;
  logic signed [STATE_W-1:0] es_r, es_nxt, acc_r, acc_nxt;
  logic signed [IW-1:0]     s1_r, inc_r;
  logic signed [LW-1:0]     lim_r, lim_nxt;

  logic signed [DW1-1:0]    raw_err, lim_pos, lim_neg, err_clip;
  logic signed [EW+8-1:0]   e_q;
  logic signed [SW1-1:0]    es_sum, acc_sum;
  logic signed [PPW-FRAC_W-1:0] tp;
  logic signed [DPW-FRAC_W-1:0] td;
  logic signed [IPW-FRAC_W-1:0] ti;
  logic signed [LW-1:0]     bnd;
  logic signed [IW-1:0]     bound, bound_neg;
  logic signed [STATE_W-1:0] omax, omin, clip_hi;

  logic start1, start2;
  logic busy_e, busy_b, busy_p, busy_d, busy_i;
  logic signed [EPW-1:0] e_prod;
  logic signed [BPW-1:0] b_prod;
  logic signed [PPW-1:0] p_prod;
  logic signed [DPW-1:0] d_prod;
  logic signed [IPW-1:0] i_prod;

  rlpid_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
  assign start1    = (state_r == S_GO1);
  assign start2    = (state_r == S_GO2);

  // first pass: integral step and rate bound (dt serial), proportional term
  rlpid_smul #(.WA(EW), .WB(TIME_W), .B_SIGNED(1'b0)) u_mul_e (
    .clk(clk), .rst_n(rst_n), .start(start1),
    .a(err_r), .b(dt_r), .busy(busy_e), .prod(e_prod)
  );

  rlpid_smul #(.WA(DATA_W), .WB(TIME_W), .B_SIGNED(1'b0)) u_mul_b (
    .clk(clk), .rst_n(rst_n), .start(start1),
    .a($signed({1'b0, cfg.max_rate})), .b(dt_r), .busy(busy_b), .prod(b_prod)
  );

  rlpid_smul #(.WA(DATA_W), .WB(EW), .B_SIGNED(1'b1)) u_mul_p (
    .clk(clk), .rst_n(rst_n), .start(start1),
    .a(cfg.kp), .b(err_r), .busy(busy_p), .prod(p_prod)
  );

  // second pass: integral and differential terms
  rlpid_smul #(.WA(DATA_W), .WB(EW + 1), .B_SIGNED(1'b1)) u_mul_d (
    .clk(clk), .rst_n(rst_n), .start(start2),
    .a(cfg.kd), .b(diff_r), .busy(busy_d), .prod(d_prod)
  );

  rlpid_smul #(.WA(STATE_W), .WB(DATA_W), .B_SIGNED(1'b1)) u_mul_i (
    .clk(clk), .rst_n(rst_n), .start(start2),
    .a(es_r), .b(cfg.ki), .busy(busy_i), .prod(i_prod)
  );

  // error clamp on the incoming beat
  always_comb begin
    raw_err = $signed({cfg.target[DATA_W-1], cfg.target})
            - $signed({in_measured[DATA_W-1], in_measured});
    lim_pos = $signed({1'b0, DATA_W'(ERROR_LIMIT)});
    lim_neg = -lim_pos;
    priority if (raw_err > lim_pos) begin
      err_clip = lim_pos;
    end else if (raw_err < lim_neg) begin
      err_clip = lim_neg;
    end else begin
      err_clip = raw_err;
    end
    err_nxt  = err_clip[EW-1:0];
    diff_nxt = $signed({err_r[EW-1], err_r}) - $signed({last_err_r[EW-1], last_err_r});
  end

  // floored Q.16 products are the arithmetic top slices
  always_comb begin
    e_q = e_prod[EPW-1:FRAC_W];
    tp  = p_prod[PPW-1:FRAC_W];
    td  = d_prod[DPW-1:FRAC_W];
    ti  = i_prod[IPW-1:FRAC_W];
    bnd = $signed({1'b0, b_prod[BPW-1:FRAC_W]});
    bound     = IW'(bnd);
    bound_neg = -bound;

    es_sum = SW1'(es_r) + SW1'(e_q);
    if (es_sum[STATE_W] != es_sum[STATE_W-1]) begin
      es_nxt = es_sum[STATE_W] ? SAT_MIN : SAT_MAX;
    end else begin
      es_nxt = es_sum[STATE_W-1:0];
    end

    priority if (inc_r >= bound) begin
      lim_nxt = LW'(bound);
    end else if (inc_r <= bound_neg) begin
      lim_nxt = LW'(bound_neg);
    end else begin
      lim_nxt = LW'(inc_r);
    end

    acc_sum = SW1'(acc_r) + SW1'(lim_r);
    if (acc_sum[STATE_W] != acc_sum[STATE_W-1]) begin
      acc_nxt = acc_sum[STATE_W] ? SAT_MIN : SAT_MAX;
    end else begin
      acc_nxt = acc_sum[STATE_W-1:0];
    end

    // crossed limits resolve to out_min
    omax    = STATE_W'(cfg.out_max);
    omin    = STATE_W'(cfg.out_min);
    clip_hi = (acc_r > omax) ? omax : acc_r;
    drive_nxt = (clip_hi < omin) ? cfg.out_min : clip_hi[DATA_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_GO1;
      S_GO1:  state_nxt = S_MUL1;
      S_MUL1: if (!busy_e) state_nxt = S_ISUM;
      S_ISUM: state_nxt = S_GO2;
      S_GO2:  state_nxt = S_MUL2;
      S_MUL2: begin
        if (!(busy_e || busy_b || busy_p || busy_d || busy_i)) state_nxt = S_ADD1;
      end
      S_ADD1: state_nxt = S_ADD2;
      S_ADD2: state_nxt = S_LIM;
      S_LIM:  state_nxt = S_ACC;
      S_ACC:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_err_r  <= '0;
      es_r        <= '0;
      acc_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_GO1) begin
        last_err_r <= err_r;
      end
      if (state_r == S_ISUM) begin
        es_r <= es_nxt;
      end
      if (cfg.acc_load) begin
        acc_r <= STATE_W'(cfg.init_val);
      end else if (state_r == S_ACC) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dt_r  <= in_step_time;
      err_r <= err_nxt;
    end
    if (state_r == S_GO1) begin
      diff_r <= diff_nxt;
    end
    if (state_r == S_ADD1) begin
      s1_r <= IW'(tp) + IW'(td);
    end
    if (state_r == S_ADD2) begin
      inc_r <= s1_r + IW'(ti);
    end
    if (state_r == S_LIM) begin
      lim_r <= lim_nxt;
    end
    if (state_r == S_OUT && out_free) begin
      out_drive_r <= drive_nxt;
    end
  end

endmodule

@@ rtl/core/rlpid_smul.sv @@
module rlpid_smul #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter bit B_SIGNED = 1'b1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [WA-1:0]    a,
  input  logic [WB-1:0]           b,
  output logic                    busy,
  output logic signed [WA+WB-1:0] prod
);

  localparam int CW  = $clog2(WB + 1);
  localparam int SUW = WA + 2;

  logic [CW-1:0]          cnt_r;
  logic signed [WA-1:0]   a_r;
  logic [WB-1:0]          b_r;
  logic signed [WA:0]     hi_r;
  logic [WB-1:0]          lo_r;
  logic                   last_bit;
  logic signed [SUW-1:0]  addend;
  logic signed [SUW-1:0]  sum;

  // one multiplier bit per cycle, lsb first; product low bits shift into lo_r
  always_comb begin
    last_bit = (cnt_r == CW'(1));
    if (!b_r[0]) begin
      addend = '0;
    end else if (B_SIGNED && last_bit) begin
      addend = -SUW'(a_r);  // sign bit of a two's complement multiplier
    end else begin
      addend = SUW'(a_r);
    end
    sum = SUW'(hi_r) + addend;
  end

  assign busy = (cnt_r != '0);
  assign prod = {hi_r[WA-1:0], lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(WB);
    end else if (busy) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      hi_r <= '0;
    end else if (busy) begin
      hi_r <= sum[SUW-1:1];
      lo_r <= {sum[0], lo_r[WB-1:1]};
      b_r  <= b_r >> 1;
    end
  end

endmodule

@@ rtl/core/rlpid_cfg_regs.sv @@
module rlpid_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [rlpid_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [rlpid_pkg::DATA_W-1:0]      wr_data,
  output rlpid_pkg::rlpid_cfg_t             cfg
);

  import rlpid_pkg::*;

  logic signed [DATA_W-1:0] kp_r;
  logic signed [DATA_W-1:0] ki_r;
  logic signed [DATA_W-1:0] kd_r;
  logic signed [DATA_W-1:0] target_r;
  logic [RATE_W-1:0]        max_rate_r;
  logic signed [DATA_W-1:0] out_max_r;
  logic signed [DATA_W-1:0] out_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= KP_RST;
      ki_r       <= KI_RST;
      kd_r       <= KD_RST;
      target_r   <= TARGET_RST;
      max_rate_r <= MAX_RATE_RST;
      out_max_r  <= OUT_MAX_RST;
      out_min_r  <= OUT_MIN_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KP:       kp_r       <= wr_data;
        REG_KI:       ki_r       <= wr_data;
        REG_KD:       kd_r       <= wr_data;
        REG_TARGET:   target_r   <= wr_data;
        REG_MAX_RATE: max_rate_r <= wr_data[RATE_W-1:0];
        REG_OUT_MAX:  out_max_r  <= wr_data;
        REG_OUT_MIN:  out_min_r  <= wr_data;
        default: ;  // initial output goes straight to the accumulator; other indices are ignored
      endcase
    end
  end

  always_comb begin
    cfg.kp       = kp_r;
    cfg.ki       = ki_r;
    cfg.kd       = kd_r;
    cfg.target   = target_r;
    cfg.max_rate = max_rate_r;
    cfg.out_max  = out_max_r;
    cfg.out_min  = out_min_r;
    cfg.acc_load = wr_en && (wr_index == REG_INIT_OUT);
    cfg.init_val = wr_data;
  end

endmodule

@@ rtl/core/rlpid_checker.sv @@
`include "assert_macros.svh"

module rlpid_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [rlpid_pkg::DATA_W-1:0] out_drive
);

  // reset empties the output and opens the input
  `ASSERT_CLK(a_reset_state, !rst_n |=> !out_valid && in_ready)

  // a waiting result holds its value
  `ASSERT_CLK_RST(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_drive))

  // one item in flight: an input beat closes the input
  `ASSERT_CLK_RST(a_one_item, in_valid && in_ready |=> !in_ready)

  // an idle block stays idle without an input beat
  `ASSERT_CLK_RST(a_idle_stays, in_ready && !in_valid |=> in_ready)

  // a new result only appears at the end of a computation
  `ASSERT_CLK_RST(a_result_after_work, $rose(out_valid) |-> $past(!in_ready))

endmodule

bind rate_limited_pid_heading_regulator_unit rlpid_checker u_rlpid_checker (.*);

@@ tb/rate_limited_pid_heading_regulator_unit_tb.sv @@
module rate_limited_pid_heading_regulator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlpid_pkg::*;

  localparam longint ERR_LIM      = longint'(ERROR_LIMIT_DEFAULT);
  localparam int     CYCLE_LIMIT  = 2_000_000;
  localparam int     DRAIN_CYCLES = 80;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic signed [DATA_W-1:0]   in_measured  = '0;
  logic [TIME_W-1:0]          in_step_time = '0;
  logic                       out_ready    = 1'b0;
  logic                       cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index    = '0;
  logic [DATA_W-1:0]          cfg_data     = '0;
  logic                       in_ready;
  logic                       out_valid;
  logic signed [DATA_W-1:0]   out_drive;
  logic                       cfg_ready;

  rate_limited_pid_heading_regulator_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_measured  (in_measured),
    .in_step_time (in_step_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_drive    (out_drive),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // regulator copy: settings and loop state
  logic signed [DATA_W-1:0]  m_kp, m_ki, m_kd, m_target, m_out_max, m_out_min;
  logic [RATE_W-1:0]         m_max_rate;
  logic signed [DATA_W-1:0]  m_last_err;
  logic signed [STATE_W-1:0] m_err_sum, m_drive_acc;

  logic signed [DATA_W-1:0] expected_drive[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int items_sent     = 0;
  int drive_checked  = 0;
  int reg_writes     = 0;
  int cycle_count    = 0;

  function automatic bit coin();
    return $urandom_range(1) == 1;
  endfunction

  // floor(k * x / 2^16)
  function automatic logic signed [95:0] scale_q16(input logic signed [95:0] k,
                                                   input logic signed [95:0] x);
    return (k * x) >>> FRAC_W;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [95:0] v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v[STATE_W-1:0];
  endfunction

  function automatic void regulator_reset();
    m_kp        = KP_RST;
    m_ki        = KI_RST;
    m_kd        = KD_RST;
    m_target    = TARGET_RST;
    m_max_rate  = MAX_RATE_RST;
    m_out_max   = OUT_MAX_RST;
    m_out_min   = OUT_MIN_RST;
    m_last_err  = '0;
    m_err_sum   = '0;
    m_drive_acc = '0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [DATA_W-1:0] data);
    case (idx)
      REG_KP:       m_kp       = data;
      REG_KI:       m_ki       = data;
      REG_KD:       m_kd       = data;
      REG_TARGET:   m_target   = data;
      REG_MAX_RATE: m_max_rate = data[RATE_W-1:0];
      REG_OUT_MAX:  m_out_max  = data;
      REG_OUT_MIN:  m_out_min  = data;
      REG_INIT_OUT: begin
        m_drive_acc = $signed(data);
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_drive(input logic signed [DATA_W-1:0] measured,
                                        input logic [TIME_W-1:0] step);
    logic signed [95:0] err, diff, inc, bound, res, dt;
    dt  = {72'd0, step};
    err = m_target;
    err = err - measured;
    if (err > ERR_LIM) err = ERR_LIM;
    if (err < -ERR_LIM) err = -ERR_LIM;
    m_err_sum  = sat_state(m_err_sum + scale_q16(err, dt));
    diff       = err - m_last_err;
    m_last_err = err[DATA_W-1:0];
    inc = scale_q16(m_kp, err) + scale_q16(m_ki, m_err_sum) + scale_q16(m_kd, diff);
    bound = scale_q16(dt, {65'd0, m_max_rate});
    if (inc >= bound) inc = bound;
    else if (inc <= -bound) inc = -bound;
    m_drive_acc = sat_state(m_drive_acc + inc);
    res = m_drive_acc;
    if (res > m_out_max) res = m_out_max;
    if (res < m_out_min) res = m_out_min;
    expected_drive.push_back(res[DATA_W-1:0]);
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 30) $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic send_heading(input logic signed [DATA_W-1:0] measured,
                              input logic [TIME_W-1:0] step);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_measured  <= measured;
    in_step_time <= step;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_drive(measured, step);
    items_sent++;
  endtask

  // leaves cfg_valid high; release_cfg drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, data);
    reg_writes++;
  endtask

  task automatic release_cfg();
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
  endtask

  // result side
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_drive.size() == 0) begin
        report_mismatch($sformatf("drive beat %h with nothing expected", out_drive));
      end else begin
        want = expected_drive.pop_front();
        if (out_drive !== want)
          report_mismatch($sformatf("drive got %h expected %h", out_drive, want));
      end
      drive_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d drive beats outstanding",
               cycle_count, expected_drive.size());
      $display("rate_limited_pid_heading_regulator_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(4))
      0:       return $urandom;
      1:       return $urandom_range(0, 262144) - 131072;
      2:       return 65536 + $urandom_range(0, 65536) - 32768;
      3:       return '0;
      default: return coin() ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_rate();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1 << 20);
      2:       return '0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_target();
    case ($urandom_range(2))
      0:       return $urandom;
      1:       return $urandom_range(0, 1 << 25) - (1 << 24);
      default: return coin() ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] random_measured();
    int span, off;
    span = int'(2 * ERR_LIM);
    case ($urandom_range(3))
      0: return $urandom;
      1, 2: begin
        off = int'($urandom_range(0, 2 * span)) - span;
        return m_target + off;
      end
      default: begin
        off = int'($urandom_range(0, 4)) - 2;
        return coin() ? m_target + int'(ERR_LIM) + off : m_target - int'(ERR_LIM) + off;
      end
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] random_step();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(0, 4095);
      2:       return $urandom_range(0, 196608);
      default: return coin() ? '1 : '0;
    endcase
  endfunction

  task automatic randomize_settings();
    logic [DATA_W-1:0] hi, lo;
    if (coin()) write_reg(REG_KP, pick_gain());
    if (coin()) write_reg(REG_KI, pick_gain());
    if (coin()) write_reg(REG_KD, pick_gain());
    if (coin()) write_reg(REG_TARGET, pick_target());
    if (coin()) write_reg(REG_MAX_RATE, pick_rate());
    if (coin()) begin
      case ($urandom_range(3))
        0: begin
          hi = $urandom_range(0, 1 << 24);
          lo = -$urandom_range(0, 1 << 24);
        end
        1: begin
          hi = $urandom;
          lo = $urandom;
        end
        2: begin
          hi = 32'h7FFF_FFFF;
          lo = 32'h8000_0000;
        end
        default: begin
          // crossed clamps
          lo = $urandom_range(1, 1 << 22);
          hi = -$urandom_range(0, 1 << 22);
        end
      endcase
      write_reg(REG_OUT_MAX, hi);
      write_reg(REG_OUT_MIN, lo);
    end
    if ($urandom_range(3) == 0)
      write_reg(REG_INIT_OUT, coin() ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21));
    if ($urandom_range(7) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_INIT_OUT + 1, ~REG_KP)), $urandom);
    release_cfg();
  endtask

  task automatic test_reset_defaults();
    send_heading(-32'sd65536, 24'h01_0000);
    send_heading(32'sd131072, 24'h00_8000);
    send_heading(32'sd0, 24'h00_0100);
    send_heading(32'sd5000000, 24'h02_0000);
  endtask

  task automatic test_field_extremes();
    wait_idle();
    write_reg(REG_KD, 32'h0000_8000);
    release_cfg();
    send_heading(32'sd0, 24'h00_0000);
    send_heading(32'sh7FFF_FFFF, 24'hFF_FFFF);
    send_heading(32'sh8000_0000, 24'hFF_FFFF);
    // error exactly at and just past the limit, both signs
    send_heading(32'(-ERR_LIM), 24'h00_0001);
    send_heading(32'(-ERR_LIM - 1), 24'h00_0001);
    send_heading(32'(ERR_LIM), 24'h00_0001);
    send_heading(32'(ERR_LIM + 1), 24'h00_0001);
    send_heading(32'sh8000_0000, 24'h00_0000);
    send_heading(32'sh7FFF_FFFF, 24'h80_0000);
    send_heading(32'sh5555_5555, 24'hAA_AAAA);
    send_heading(32'shAAAA_AAAA, 24'h55_5555);
    send_heading(32'sd0, 24'hFF_FFFF);
  endtask

  task automatic test_register_writes();
    wait_idle();
    write_reg(REG_KP, 32'd65536);
    write_reg(REG_KI, 32'd0);
    write_reg(REG_KD, 32'd0);
    write_reg(REG_TARGET, 32'd0);
    write_reg(REG_MAX_RATE, 32'd65536);
    write_reg(REG_OUT_MAX, 32'h7FFF_FFFF);
    write_reg(REG_OUT_MIN, 32'h8000_0000);
    write_reg(REG_INIT_OUT, 32'd0);
    release_cfg();
    // increment equal to the rate bound, then its negative, then past it
    send_heading(-32'sd65536, 24'h01_0000);
    send_heading(32'sd65536, 24'h01_0000);
    send_heading(-32'sd131072, 24'h01_0000);

    wait_idle();
    write_reg(REG_MAX_RATE, 32'hFFFF_FFFF);
    write_reg(REG_KP, 32'h8000_0000);
    write_reg(REG_KD, 32'h7FFF_FFFF);
    write_reg(REG_TARGET, 32'h7FFF_FFFF);
    release_cfg();
    send_heading(32'sd0, 24'h00_0400);
    send_heading(32'sh7FFF_FFFF, 24'h00_0400);

    wait_idle();
    write_reg(REG_OUT_MAX, 32'hFFFF_0000);
    write_reg(REG_OUT_MIN, 32'h0001_0000);
    release_cfg();
    send_heading(32'sd0, 24'h00_1000);
    send_heading(32'sh8000_0000, 24'h00_1000);

    wait_idle();
    write_reg(CFG_IDX_W'(REG_INIT_OUT + 1), 32'hDEAD_BEEF);
    write_reg(~REG_KP, 32'h1234_5678);
    write_reg(REG_MAX_RATE, 32'd0);
    write_reg(REG_OUT_MAX, 32'h7FFF_FFFF);
    write_reg(REG_OUT_MIN, 32'h8000_0000);
    write_reg(REG_INIT_OUT, 32'h7FFF_FFFF);
    release_cfg();
    send_heading(32'sd12345, 24'hFF_FFFF);
    send_heading(-32'sd999999, 24'h00_0001);

    wait_idle();
    write_reg(REG_KP, KP_RST);
    write_reg(REG_KI, KI_RST);
    write_reg(REG_KD, KD_RST);
    write_reg(REG_TARGET, TARGET_RST);
    write_reg(REG_MAX_RATE, 32'(MAX_RATE_RST));
    write_reg(REG_OUT_MAX, OUT_MAX_RST);
    write_reg(REG_OUT_MIN, OUT_MIN_RST);
    write_reg(REG_INIT_OUT, 32'd0);
    release_cfg();
    send_heading(32'sd65536, 24'h00_4000);
  endtask

  // each beat moves the accumulator by the full rate bound (about 2^39), so
  // a few hundred beats reach either end of the 48-bit range
  task automatic test_accumulator_saturation();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    wait_idle();
    write_reg(REG_KP, 32'd0);
    write_reg(REG_KI, 32'h7FFF_FFFF);
    write_reg(REG_KD, 32'd0);
    write_reg(REG_TARGET, 32'd0);
    write_reg(REG_MAX_RATE, 32'h7FFF_FFFF);
    write_reg(REG_OUT_MAX, 32'h7FFF_FFFF);
    write_reg(REG_OUT_MIN, 32'h8000_0000);
    write_reg(REG_INIT_OUT, 32'h7FFF_FFFF);
    release_cfg();
    repeat (260) send_heading(32'sh8000_0000, 24'hFF_FFFF);
    wait_idle();
    write_reg(REG_KI, 32'h8000_0000);
    release_cfg();
    repeat (260) send_heading(32'sh8000_0000, 24'hFF_FFFF);
    wait_idle();
    write_reg(REG_INIT_OUT, 32'h8000_0000);
    release_cfg();
    repeat (260) send_heading(32'sh8000_0000, 24'hFF_FFFF);
    wait_idle();
    write_reg(REG_KI, 32'h7FFF_FFFF);
    release_cfg();
    repeat (260) send_heading(32'sh8000_0000, 24'hFF_FFFF);
  endtask

  task automatic test_random_traffic(input int sender_pct, input int stall_pct,
                                     input int n_items);
    int left, chunk;
    send_idle_pct  = sender_pct;
    recv_stall_pct = stall_pct;
    left = n_items;
    while (left > 0) begin
      chunk = $urandom_range(12, 40);
      if (chunk > left) chunk = left;
      wait_idle();
      randomize_settings();
      repeat (chunk) send_heading(random_measured(), random_step());
      left -= chunk;
    end
  endtask

  initial begin
    regulator_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_register_writes();
    test_accumulator_saturation();
    test_random_traffic(0, 0, 220);
    test_random_traffic(88, 0, 220);
    test_random_traffic(0, 88, 220);
    test_random_traffic(20, 20, 220);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_drive.size() != 0)
      report_mismatch($sformatf("%0d drive beats never arrived", expected_drive.size()));

    $display("sent %0d headings: reset defaults, field extremes, every register, crossed",
             items_sent);
    $display("clamps, 48-bit saturation both ways; %0d drive beats checked, %0d writes",
             drive_checked, reg_writes);
    if (fail_count == 0) begin
      $display("rate_limited_pid_heading_regulator_unit_tb: PASS");
    end else begin
      $display("rate_limited_pid_heading_regulator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rlpid_pkg.sv
rtl/core/rlpid_smul.sv
rtl/core/rlpid_cfg_regs.sv
rtl/core/rate_limited_pid_heading_regulator_unit.sv
rtl/core/rlpid_checker.sv
tb/rate_limited_pid_heading_regulator_unit_tb.sv
